@@ hdl/ata_tf_pkg.sv @@
`default_nettype none

package ata_tf_pkg;

  // Widths of the host-side fields.
  localparam int ADDR_W  = 7;
  localparam int DATA_W  = 16;
  localparam int IDX_W   = 3;
  localparam int CODE_W  = 8;
  localparam int SLOT_W  = 4;
  localparam int RF_DEPTH = 16;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] CFG_REG_PACKET_CODE = 1'b0;
  localparam logic [CODE_W-1:0] PACKET_CODE_RESET = 8'hA0;

  // Default packet length in words.
  localparam int PACKET_WORDS_DEFAULT = 6;

  // Register file slots.
  localparam logic [SLOT_W-1:0] SLOT_STATUS  = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_COMMAND = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_BCL     = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_BCH     = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_DATA    = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_DEVCTL  = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_SELECT  = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_ERROR   = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_FEATURE = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_IREASON = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_SECCNT  = 4'd12;
  localparam logic [SLOT_W-1:0] SLOT_SECTOR  = 4'd13;
  localparam logic [SLOT_W-1:0] SLOT_DUMP    = 4'd14;

  // Bus addresses that trigger actions.
  localparam logic [ADDR_W-1:0] ADDR_ALT_STATUS = 7'h4E;
  localparam logic [ADDR_W-1:0] ADDR_COMMAND    = 7'h37;
  localparam logic [ADDR_W-1:0] ADDR_DATA_WRITE = 7'h30;
  localparam int READ_BIT = 6;

  // Register values.
  localparam logic [DATA_W-1:0] STATUS_RESET   = 16'h0040;
  localparam logic [DATA_W-1:0] SELECT_RESET   = 16'h00A0;
  localparam logic [DATA_W-1:0] SECTOR_RESET   = 16'h0040;
  localparam logic [DATA_W-1:0] STATUS_PACKET  = 16'h0058;
  localparam logic [DATA_W-1:0] STATUS_DONE    = 16'h0050;
  localparam logic [DATA_W-1:0] BSY_CLEAR_MASK = 16'hFF7F;
  localparam logic [DATA_W-1:0] IREASON_CMD    = 16'h0001;
  localparam logic [DATA_W-1:0] IREASON_DONE   = 16'h0002;

  // One result of a host access.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              interrupt_request;
    logic              packet_mode_active;
    logic              packet_word_valid;
    logic [IDX_W-1:0]  packet_word_index;
    logic [DATA_W-1:0] packet_word;
    logic              packet_last;
  } rsp_t;

  // Address map of the task file; unmapped addresses land in the dump slot.
  function automatic logic [SLOT_W-1:0] slot_of(input logic [ADDR_W-1:0] addr);
    logic [SLOT_W-1:0] s;
    case (addr)
      7'h4E, 7'h57: s = SLOT_STATUS;
      7'h37:        s = SLOT_COMMAND;
      7'h34, 7'h54: s = SLOT_BCL;
      7'h35, 7'h55: s = SLOT_BCH;
      7'h30, 7'h50: s = SLOT_DATA;
      7'h2E:        s = SLOT_DEVCTL;
      7'h36, 7'h56: s = SLOT_SELECT;
      7'h51:        s = SLOT_ERROR;
      7'h31:        s = SLOT_FEATURE;
      7'h52:        s = SLOT_IREASON;
      7'h32:        s = SLOT_SECCNT;
      7'h53:        s = SLOT_SECTOR;
      default:      s = SLOT_DUMP;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hdl/ata_tf_req_if.sv @@
`default_nettype none

interface ata_tf_req_if;
  logic                          valid;
  logic                          ready;
  logic [ata_tf_pkg::ADDR_W-1:0] bus_address;
  logic [ata_tf_pkg::DATA_W-1:0] write_data;

  modport source (output valid, output bus_address, output write_data, input ready);
  modport sink (input valid, input bus_address, input write_data, output ready);
endinterface

`default_nettype wire

@@ hdl/ata_tf_rsp_if.sv @@
`default_nettype none

interface ata_tf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ata_tf_pkg::DATA_W-1:0] read_data;
  logic                          interrupt_request;
  logic                          packet_mode_active;
  logic                          packet_word_valid;
  logic [ata_tf_pkg::IDX_W-1:0]  packet_word_index;
  logic [ata_tf_pkg::DATA_W-1:0] packet_word;
  logic                          packet_last;

  modport source (
    output valid, output read_data, output interrupt_request,
    output packet_mode_active, output packet_word_valid,
    output packet_word_index, output packet_word, output packet_last,
    input ready
  );
  modport sink (
    input valid, input read_data, input interrupt_request,
    input packet_mode_active, input packet_word_valid,
    input packet_word_index, input packet_word, input packet_last,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/ata_tf_cfg.sv @@
`default_nettype none

module ata_tf_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ata_tf_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [ata_tf_pkg::PDATA_W-1:0]    pwdata,
  output logic      [ata_tf_pkg::PDATA_W-1:0]    prdata,
  output logic                                   pready,
  output logic      [ata_tf_pkg::CODE_W-1:0]     packet_command_code
);

  logic reg_hit;

  // Register index is the word address.
  assign reg_hit = (paddr[ata_tf_pkg::PADDR_W-1] == ata_tf_pkg::CFG_REG_PACKET_CODE);
  assign pready  = 1'b1;

  // Packet command code register.
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_command_code <= ata_tf_pkg::PACKET_CODE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      packet_command_code <= pwdata[ata_tf_pkg::CODE_W-1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata[ata_tf_pkg::CODE_W-1:0] = packet_command_code;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ata_tf_exec.sv @@
`default_nettype none

module ata_tf_exec #(
  parameter int PACKET_WORDS = ata_tf_pkg::PACKET_WORDS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [ata_tf_pkg::ADDR_W-1:0] bus_address,
  input  wire logic [ata_tf_pkg::DATA_W-1:0] write_data,
  input  wire logic [ata_tf_pkg::CODE_W-1:0] packet_command_code,
  output ata_tf_pkg::rsp_t                   result
);

  localparam int CNT_W = (PACKET_WORDS > 1) ? $clog2(PACKET_WORDS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PACKET_WORDS - 1);

  logic [ata_tf_pkg::DATA_W-1:0] rf [ata_tf_pkg::RF_DEPTH];
  logic [ata_tf_pkg::DATA_W-1:0] rf_next [ata_tf_pkg::RF_DEPTH];
  logic                          packet_mode, packet_mode_next;
  logic [CNT_W-1:0]              packet_count, packet_count_next;
  logic                          interrupt_level, interrupt_level_next;

  logic [ata_tf_pkg::SLOT_W-1:0]      slot;
  logic                               is_read;
  logic [CNT_W+ata_tf_pkg::IDX_W-1:0] idx_ext;

  assign slot    = ata_tf_pkg::slot_of(bus_address);
  assign is_read = bus_address[ata_tf_pkg::READ_BIT];
  assign idx_ext = {{ata_tf_pkg::IDX_W{1'b0}}, packet_count};

  // Access, then the action it triggers.
  always_comb begin
    rf_next              = rf;
    packet_mode_next     = packet_mode;
    packet_count_next    = packet_count;
    interrupt_level_next = interrupt_level;
    result               = '0;

    if (is_read) begin
      result.read_data = rf[slot];
    end else begin
      rf_next[slot] = write_data;
    end

    if (bus_address == ata_tf_pkg::ADDR_ALT_STATUS) begin
      interrupt_level_next = 1'b0;
    end else if (packet_mode) begin
      if (bus_address == ata_tf_pkg::ADDR_DATA_WRITE) begin
        result.packet_word_valid = 1'b1;
        result.packet_word_index = idx_ext[ata_tf_pkg::IDX_W-1:0];
        result.packet_word       = write_data;
        if (packet_count == CNT_LAST) begin
          result.packet_last                   = 1'b1;
          packet_count_next                    = '0;
          packet_mode_next                     = 1'b0;
          rf_next[ata_tf_pkg::SLOT_STATUS]     = ata_tf_pkg::STATUS_DONE;
          rf_next[ata_tf_pkg::SLOT_IREASON]    = ata_tf_pkg::IREASON_DONE;
          interrupt_level_next                 = 1'b1;
        end else begin
          packet_count_next = packet_count + CNT_W'(1);
        end
      end
    end else if (bus_address == ata_tf_pkg::ADDR_COMMAND) begin
      // The command address is always a write, so the new command is write_data.
      if (write_data == {{(ata_tf_pkg::DATA_W - ata_tf_pkg::CODE_W){1'b0}},
                         packet_command_code}) begin
        packet_mode_next                  = 1'b1;
        packet_count_next                 = '0;
        rf_next[ata_tf_pkg::SLOT_IREASON] = ata_tf_pkg::IREASON_CMD;
        rf_next[ata_tf_pkg::SLOT_STATUS]  = ata_tf_pkg::STATUS_PACKET;
      end else begin
        rf_next[ata_tf_pkg::SLOT_STATUS] =
          rf[ata_tf_pkg::SLOT_STATUS] & ata_tf_pkg::BSY_CLEAR_MASK;
      end
    end

    result.interrupt_request  = interrupt_level_next;
    result.packet_mode_active = packet_mode_next;
  end

  // Task file and packet state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ata_tf_pkg::RF_DEPTH; i++) begin
        if (i == int'(ata_tf_pkg::SLOT_STATUS)) begin
          rf[i] <= ata_tf_pkg::STATUS_RESET;
        end else if (i == int'(ata_tf_pkg::SLOT_SELECT)) begin
          rf[i] <= ata_tf_pkg::SELECT_RESET;
        end else if (i == int'(ata_tf_pkg::SLOT_SECTOR)) begin
          rf[i] <= ata_tf_pkg::SECTOR_RESET;
        end else begin
          rf[i] <= '0;
        end
      end
      packet_mode     <= 1'b0;
      packet_count    <= '0;
      interrupt_level <= 1'b0;
    end else if (go) begin
      rf              <= rf_next;
      packet_mode     <= packet_mode_next;
      packet_count    <= packet_count_next;
      interrupt_level <= interrupt_level_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ata_task_file_packet_front_end_core.sv @@
// ATA task file front end with packet command, device side.
// Each request on req is one host bus access: bus_address holds the W, R,
// CS1, CS0 and A2..A0 bits (bit 6 set means read) and write_data the word
// for a write. Each request gives exactly one response on rsp with the read
// data, the interrupt level, the packet mode flag and, for a data write in
// packet mode, the captured packet word with its index and a last flag.
// The packet command code is set through the APB port at byte address 0;
// the user must write it only while no request is in flight; the block
// itself does not enforce this. A request is registered on acceptance and
// executed against the task file when the output register can take the
// result, landing in the output register that drives rsp. One request is
// taken per cycle while rsp is not stalled; the read-modify-write of the
// task file does not hold the flow.
// When rsp is stalled the output register and the input register hold, and
// req.ready drops once both are full; nothing is lost or repeated.
// Synchronous reset empties both registers, loads the task file with its
// idle values (status 0x40, drive select 0xA0, sector number 0x40), leaves
// packet mode, clears the interrupt and sets the packet code to 0xA0.
`default_nettype none

module ata_task_file_packet_front_end_core #(
  parameter int PACKET_WORDS = ata_tf_pkg::PACKET_WORDS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  ata_tf_req_if.sink                          req,
  ata_tf_rsp_if.source                        rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ata_tf_pkg::PADDR_W-1:0] paddr,
  input  wire logic [ata_tf_pkg::PDATA_W-1:0] pwdata,
  output logic      [ata_tf_pkg::PDATA_W-1:0] prdata,
  output logic                                pready
);

  logic                          in_valid;
  logic [ata_tf_pkg::ADDR_W-1:0] in_address;
  logic [ata_tf_pkg::DATA_W-1:0] in_data;
  logic                          out_valid;
  ata_tf_pkg::rsp_t              out_rsp;
  ata_tf_pkg::rsp_t              exec_rsp;
  logic [ata_tf_pkg::CODE_W-1:0] packet_command_code;
  logic                          out_free;
  logic                          go;

  // Configuration register.
  ata_tf_cfg u_cfg (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .packet_command_code (packet_command_code)
  );

  // Flow control: execute when the output register can take the result.
  assign out_free  = !out_valid || rsp.ready;
  assign go        = in_valid && out_free;
  assign req.ready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_address <= req.bus_address;
      in_data    <= req.write_data;
    end
  end

  // Task file execution.
  ata_tf_exec #(
    .PACKET_WORDS (PACKET_WORDS)
  ) u_exec (
    .clk                 (clk),
    .rst                 (rst),
    .go                  (go),
    .bus_address         (in_address),
    .write_data          (in_data),
    .packet_command_code (packet_command_code),
    .result              (exec_rsp)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_rsp <= exec_rsp;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.read_data          = out_rsp.read_data;
  assign rsp.interrupt_request  = out_rsp.interrupt_request;
  assign rsp.packet_mode_active = out_rsp.packet_mode_active;
  assign rsp.packet_word_valid  = out_rsp.packet_word_valid;
  assign rsp.packet_word_index  = out_rsp.packet_word_index;
  assign rsp.packet_word        = out_rsp.packet_word;
  assign rsp.packet_last        = out_rsp.packet_last;

endmodule

`default_nettype wire
